[rtl/pzfe_pkg.sv]
// ----------------------------------------------------------------------------
// pzfe_pkg
// Types and constants shared by the PTZ camera frame encoder modules.
// ----------------------------------------------------------------------------
package pzfe_pkg;

  // Configuration register indexes
  localparam logic REG_PROTOCOL_SELECT = 1'b0;
  localparam logic REG_PORT_OPEN       = 1'b1;

  // Framing select codes
  localparam logic PROTO_PELCO_D = 1'b0;
  localparam logic PROTO_PELCO_P = 1'b1;

  // Frame marker bytes
  localparam logic [7:0] SYNC_D  = 8'hFF;
  localparam logic [7:0] START_P = 8'hA0;
  localparam logic [7:0] END_P   = 8'hAF;

  // Command byte test masks
  localparam logic [7:0] SPEED_C2_MASK = 8'h06;
  localparam logic [7:0] SPEED_C3_MASK = 8'h19;
  localparam logic [7:0] CAM_MASK      = 8'h88;
  localparam logic [7:0] CAM_OFF_BITS  = 8'h08;
  localparam logic [7:0] SCAN_MASK     = 8'h90;
  localparam logic [7:0] SCAN_OFF_BITS = 8'h10;
  localparam logic [7:0] LOW7_MASK     = 8'h7F;

  // Translated Pelco-P command bytes
  localparam logic [7:0] P_CAM_ON   = 8'h50;
  localparam logic [7:0] P_CAM_OFF  = 8'h40;
  localparam logic [7:0] P_SCAN_ON  = 8'h20;
  localparam logic [7:0] P_SCAN_OFF = 8'h00;

  // Index of the final byte for each kind of result
  localparam logic [2:0] LAST_IDX_ERR = 3'd0;
  localparam logic [2:0] LAST_IDX_D   = 3'd6;
  localparam logic [2:0] LAST_IDX_P   = 3'd7;

  // One fully built frame, byte 0 first on the wire
  typedef struct packed {
    logic [7:0][7:0] bytes;
    logic [2:0]      last_idx;
    logic            err;
  } pzfe_frame_t;

  // Queue head as seen by the serializer
  typedef struct packed {
    logic        valid;
    pzfe_frame_t frame;
  } pzfe_head_t;

endpackage

[rtl/pzfe_front.sv]
// ----------------------------------------------------------------------------
// pzfe_front
// Classifies one command and builds its complete Pelco-D or Pelco-P frame,
// or an error result when the link is closed.
// ----------------------------------------------------------------------------
module pzfe_front (
  input  logic                 protocol_select,
  input  logic                 port_open,
  input  logic [7:0]           camera_address,
  input  logic [31:0]          command_word,
  input  logic [7:0]           speed_param,
  output pzfe_pkg::pzfe_frame_t frame
);

  logic [7:0] c0, c1, c2, c3;
  logic [7:0] d2, d3;
  logic [7:0] p0, p1;
  logic [7:0] sum_d;
  logic [7:0] xor_p;

  // Split the command word and apply speed to the data bytes
  always_comb begin
    c0 = command_word[31:24];
    c1 = command_word[23:16];
    c2 = command_word[15:8];
    c3 = command_word[7:0];
    d2 = ((c1 & pzfe_pkg::SPEED_C2_MASK) != 8'h00) ? c2 + speed_param : c2;
    d3 = ((c1 & pzfe_pkg::SPEED_C3_MASK) != 8'h00) ? c3 + speed_param : c3;
  end

  // Translate command bytes for Pelco-P, first match wins
  always_comb begin
    p0 = c0;
    p1 = c1;
    if ((c0 & pzfe_pkg::CAM_MASK) == pzfe_pkg::CAM_MASK) begin
      p0 = pzfe_pkg::P_CAM_ON;
    end else if ((c0 & pzfe_pkg::CAM_MASK) == pzfe_pkg::CAM_OFF_BITS) begin
      p0 = pzfe_pkg::P_CAM_OFF;
    end else if ((c0 & pzfe_pkg::SCAN_MASK) == pzfe_pkg::SCAN_MASK) begin
      p0 = pzfe_pkg::P_SCAN_ON;
    end else if ((c0 & pzfe_pkg::SCAN_MASK) == pzfe_pkg::SCAN_OFF_BITS) begin
      p0 = pzfe_pkg::P_SCAN_OFF;
    end else if (!c1[0]) begin
      // Direction bits shift up by one
      p0 = {1'b0, command_word[29:23]};
      p1 = c1 & pzfe_pkg::LOW7_MASK;
    end
  end

  // Checksums
  always_comb begin
    sum_d = camera_address + c0 + c1 + d2 + d3;
    xor_p = pzfe_pkg::START_P ^ camera_address ^ p0 ^ p1 ^ d2 ^ d3 ^ pzfe_pkg::END_P;
  end

  // Assemble the frame
  always_comb begin
    frame.bytes = '0;
    frame.err   = 1'b0;
    if (!port_open) begin
      frame.err      = 1'b1;
      frame.last_idx = pzfe_pkg::LAST_IDX_ERR;
    end else if (protocol_select == pzfe_pkg::PROTO_PELCO_D) begin
      frame.bytes[0] = pzfe_pkg::SYNC_D;
      frame.bytes[1] = camera_address;
      frame.bytes[2] = c0;
      frame.bytes[3] = c1;
      frame.bytes[4] = d2;
      frame.bytes[5] = d3;
      frame.bytes[6] = sum_d;
      frame.last_idx = pzfe_pkg::LAST_IDX_D;
    end else begin
      frame.bytes[0] = pzfe_pkg::START_P;
      frame.bytes[1] = camera_address;
      frame.bytes[2] = p0;
      frame.bytes[3] = p1;
      frame.bytes[4] = d2;
      frame.bytes[5] = d3;
      frame.bytes[6] = pzfe_pkg::END_P;
      frame.bytes[7] = xor_p;
      frame.last_idx = pzfe_pkg::LAST_IDX_P;
    end
  end

endmodule

[rtl/pzfe_queue.sv]
// ----------------------------------------------------------------------------
// pzfe_queue
// Short register FIFO of built frames between the front and the serializer.
// ----------------------------------------------------------------------------
module pzfe_queue #(
  parameter int DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  pzfe_pkg::pzfe_frame_t push_frame,
  output logic                  full,
  input  logic                  pop,
  output pzfe_pkg::pzfe_head_t  head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  pzfe_pkg::pzfe_frame_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  assign full       = (count == CNT_FULL);
  assign head.valid = (count != '0);
  assign head.frame = slots[rd_ptr];

  // Track occupancy
  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

  // Store frames
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_frame;
    end
  end

endmodule

[rtl/pzfe_back.sv]
// ----------------------------------------------------------------------------
// pzfe_back
// Serializes the frame at the queue head, one byte per cycle unless
// out_ready stalls, into an output register.
// ----------------------------------------------------------------------------
module pzfe_back (
  input  logic                 clk,
  input  logic                 rst,
  input  pzfe_pkg::pzfe_head_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           frame_byte,
  output logic                 last_of_frame,
  output logic                 link_error
);

  logic [2:0] idx;
  logic       slot_free;
  logic       emit;
  logic       at_last;

  assign slot_free = !out_valid || out_ready;
  assign emit      = slot_free && head.valid;
  assign at_last   = (idx == head.frame.last_idx);
  assign pop       = emit && at_last;

  // Step through the bytes of the head frame
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        idx <= at_last ? 3'd0 : idx + 3'd1;
      end
      if (slot_free) begin
        out_valid <= head.valid;
      end
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (emit) begin
      frame_byte    <= head.frame.bytes[idx];
      last_of_frame <= at_last;
      link_error    <= head.frame.err;
    end
  end

endmodule

[rtl/ptz_camera_frame_encoder_core.sv]
// ----------------------------------------------------------------------------
// ptz_camera_frame_encoder_core
// Encodes PTZ camera commands into Pelco-D or Pelco-P frames, emitted one
// byte per request on the output channel.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  input   | in_valid / in_ready    | camera_address, command_word, speed_param
//  output  | out_valid / out_ready  | frame_byte, last_of_frame, link_error
//  config  | cfg_we                 | cfg_index, cfg_data
//
// Each command yields 7 bytes (Pelco-D), 8 bytes (Pelco-P) or one error
// result; the serializer emits one byte per cycle unless out_ready stalls.
// The front builds a whole frame in the accept cycle and a QUEUE_DEPTH-entry
// frame queue lets it run ahead of the serializer. Reset clears both
// registers, the queue and the output valid. A stall on out_ready holds the
// output byte; in_ready drops once the queue is full.
module ptz_camera_frame_encoder_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  camera_address,
  input  logic [31:0] command_word,
  input  logic [7:0]  speed_param,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  frame_byte,
  output logic        last_of_frame,
  output logic        link_error
);

  logic                  protocol_select;
  logic                  port_open;
  logic                  q_full;
  logic                  q_pop;
  logic                  in_accept;
  pzfe_pkg::pzfe_frame_t built_frame;
  pzfe_pkg::pzfe_head_t  q_head;

  assign in_ready  = !q_full;
  assign in_accept = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_select <= 1'b0;
      port_open       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        pzfe_pkg::REG_PROTOCOL_SELECT: protocol_select <= cfg_data;
        pzfe_pkg::REG_PORT_OPEN:       port_open       <= cfg_data;
        default: ;
      endcase
    end
  end

  pzfe_front u_front (
    .protocol_select (protocol_select),
    .port_open       (port_open),
    .camera_address  (camera_address),
    .command_word    (command_word),
    .speed_param     (speed_param),
    .frame           (built_frame)
  );

  pzfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (in_accept),
    .push_frame (built_frame),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head)
  );

  pzfe_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (q_head),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .frame_byte    (frame_byte),
    .last_of_frame (last_of_frame),
    .link_error    (link_error)
  );

endmodule
